FILE: sv/bpv_pkg.sv
// ----------------------------------------------------------------------------
// bpv_pkg
// Shared sizes and the command/status bundles of the binomial prime
// valuation unit.
// ----------------------------------------------------------------------------
package bpv_pkg;

   // port widths of the request and response fields
   localparam int FIELD_W = 32;
   localparam int VAL_W   = 6;

   // largest reportable valuation, counts saturate here
   localparam logic [VAL_W-1:0] VAL_MAX = '1;

   // defaults for the top level parameters
   localparam int DEF_WIDTH       = 32;
   localparam int DEF_DIGIT_LIMIT = 32;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // take a new request beat into the operand registers
      logic cap_bad;   // capture an invalid-argument response
      logic div_init;  // clear the remainders before a digit division
      logic div_step;  // one restoring division bit on both lanes
      logic digit;     // compare the digits, update borrow and count
      logic cap_ok;    // capture the borrow count as the response
   } bpv_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic bad;       // i above n or base below two
      logic n_zero;    // no digits of n remain
   } bpv_stat_type;

endpackage

FILE: sv/bpv_ctrl.sv
// ----------------------------------------------------------------------------
// bpv_ctrl
// Sequencer of the valuation unit: validates the operands, runs one base-p
// digit division per digit of n and issues the response strobe.
// ----------------------------------------------------------------------------
module bpv_ctrl
   import bpv_pkg::*;
#(
   parameter int WIDTH       = DEF_WIDTH,
   parameter int DIGIT_LIMIT = DEF_DIGIT_LIMIT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output bpv_cmd_type  cmd,
   input  bpv_stat_type stat
);

   localparam int BIT_CW   = $clog2(WIDTH);
   localparam int DIGIT_CW = $clog2(DIGIT_LIMIT + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TEST,
      ST_DIVIDE,
      ST_DIGIT
   } state_type;

   state_type             state_ff, state_in;
   logic                  busy_ff, busy_in;
   logic                  strobe_ff, strobe_in;
   logic [BIT_CW-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_CW-1:0]   digit_cnt_ff, digit_cnt_in;
   logic                  bit_last;
   logic                  digit_done;

   assign bit_last   = (bit_cnt_ff == BIT_CW'(WIDTH - 1));
   assign digit_done = (digit_cnt_ff == DIGIT_CW'(DIGIT_LIMIT));

   // next state, counters and commands
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      strobe_in    = 1'b0;
      bit_cnt_in   = bit_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.bad) begin
               cmd.cap_bad = 1'b1;
               busy_in     = 1'b0;
               strobe_in   = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               digit_cnt_in = '0;
               state_in     = ST_TEST;
            end
         end
         ST_TEST: begin
            if (stat.n_zero || digit_done) begin
               cmd.cap_ok = 1'b1;
               busy_in    = 1'b0;
               strobe_in  = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.div_init = 1'b1;
               bit_cnt_in   = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            bit_cnt_in   = BIT_CW'(bit_cnt_ff + 1'b1);
            if (bit_last) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            cmd.digit    = 1'b1;
            digit_cnt_in = DIGIT_CW'(digit_cnt_ff + 1'b1);
            state_in     = ST_TEST;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         strobe_ff    <= 1'b0;
         bit_cnt_ff   <= '0;
         digit_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         strobe_ff    <= strobe_in;
         bit_cnt_ff   <= bit_cnt_in;
         digit_cnt_ff <= digit_cnt_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = strobe_ff;

endmodule

FILE: sv/bpv_dp.sv
// ----------------------------------------------------------------------------
// bpv_dp
// Datapath of the valuation unit: operand registers, a two-lane restoring
// divider sharing the base p, the borrow/count logic and the response
// registers.
// ----------------------------------------------------------------------------
module bpv_dp
   import bpv_pkg::*;
#(
   parameter int WIDTH = DEF_WIDTH
) (
   input  logic               clock,
   input  logic [FIELD_W-1:0] req_n_value,
   input  logic [FIELD_W-1:0] req_i_value,
   input  logic [FIELD_W-1:0] req_prime_base,
   input  bpv_cmd_type        cmd,
   output bpv_stat_type       stat,
   output logic [VAL_W-1:0]   rsp_valuation,
   output logic               rsp_divides,
   output logic               rsp_bad_input
);

   // n and i double as the dividend/quotient shift registers
   logic [WIDTH-1:0] n_ff, i_ff, p_ff;
   logic [WIDTH-1:0] rem_n_ff, rem_i_ff;
   logic             borrow_ff;
   logic [VAL_W-1:0] count_ff;
   logic [VAL_W-1:0] res_val_ff;
   logic             res_div_ff;
   logic             res_bad_ff;

   logic [WIDTH:0]   trial_n, trial_i;
   logic [WIDTH:0]   diff_n, diff_i;
   logic             ge_n, ge_i;
   logic             digit_borrow;

   // one restoring division bit per lane
   assign trial_n = {rem_n_ff, n_ff[WIDTH-1]};
   assign trial_i = {rem_i_ff, i_ff[WIDTH-1]};
   assign diff_n  = trial_n - {1'b0, p_ff};
   assign diff_i  = trial_i - {1'b0, p_ff};
   assign ge_n    = (trial_n >= {1'b0, p_ff});
   assign ge_i    = (trial_i >= {1'b0, p_ff});

   // borrow out of the current digit subtraction
   assign digit_borrow = ({1'b0, rem_n_ff} < ({1'b0, rem_i_ff} + {{WIDTH{1'b0}}, borrow_ff}));

   // operand checks
   assign stat.bad    = (i_ff > n_ff) || (p_ff[WIDTH-1:1] == '0);
   assign stat.n_zero = (n_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff      <= WIDTH'(req_n_value);
         i_ff      <= WIDTH'(req_i_value);
         p_ff      <= WIDTH'(req_prime_base);
         borrow_ff <= 1'b0;
         count_ff  <= '0;
      end
      if (cmd.div_init) begin
         rem_n_ff <= '0;
         rem_i_ff <= '0;
      end
      if (cmd.div_step) begin
         n_ff     <= {n_ff[WIDTH-2:0], ge_n};
         i_ff     <= {i_ff[WIDTH-2:0], ge_i};
         rem_n_ff <= ge_n ? diff_n[WIDTH-1:0] : trial_n[WIDTH-1:0];
         rem_i_ff <= ge_i ? diff_i[WIDTH-1:0] : trial_i[WIDTH-1:0];
      end
      // borrow chain and saturating count
      if (cmd.digit) begin
         borrow_ff <= digit_borrow;
         if (digit_borrow && (count_ff != VAL_MAX)) begin
            count_ff <= count_ff + 1'b1;
         end
      end
      // response capture
      if (cmd.cap_bad) begin
         res_val_ff <= '0;
         res_div_ff <= 1'b0;
         res_bad_ff <= 1'b1;
      end
      if (cmd.cap_ok) begin
         res_val_ff <= count_ff;
         res_div_ff <= (count_ff != '0);
         res_bad_ff <= 1'b0;
      end
   end

   assign rsp_valuation = res_val_ff;
   assign rsp_divides   = res_div_ff;
   assign rsp_bad_input = res_bad_ff;

endmodule

FILE: sv/binomial_prime_valuation_unit.sv
// ----------------------------------------------------------------------------
// binomial_prime_valuation_unit
// Exponent of a base p in C(n,i), counted as the borrows of n - i in base p.
//
//   channel   ports                      handshake
//   request   req_n_value, req_i_value,  taken when start is high, busy low
//             req_prime_base
//   response  rsp_valuation, rsp_divides, one cycle on rsp_valid, no stall
//             rsp_bad_input
//
// A bad request (i above n or base below two) is answered from the check state.
// Otherwise each base-p digit of n, at most DIGIT_LIMIT of them, takes a test,
// a bit-serial division over all WIDTH bits and a digit update, and a last test
// captures the count; rsp_valid comes in the cycle busy falls.
// Synchronous reset returns the sequencer to idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module binomial_prime_valuation_unit
   import bpv_pkg::*;
#(
   parameter int WIDTH       = DEF_WIDTH,
   parameter int DIGIT_LIMIT = DEF_DIGIT_LIMIT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FIELD_W-1:0] req_n_value,
   input  logic [FIELD_W-1:0] req_i_value,
   input  logic [FIELD_W-1:0] req_prime_base,
   output logic               rsp_valid,
   output logic [VAL_W-1:0]   rsp_valuation,
   output logic               rsp_divides,
   output logic               rsp_bad_input
);

   bpv_cmd_type  cmd;
   bpv_stat_type stat;

   // sequencer
   bpv_ctrl #(
      .WIDTH       (WIDTH),
      .DIGIT_LIMIT (DIGIT_LIMIT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   // divider and borrow counter
   bpv_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock          (clock),
      .req_n_value    (req_n_value),
      .req_i_value    (req_i_value),
      .req_prime_base (req_prime_base),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valuation  (rsp_valuation),
      .rsp_divides    (rsp_divides),
      .rsp_bad_input  (rsp_bad_input)
   );

endmodule

FILE: sv/bpv_checker.sv
// ----------------------------------------------------------------------------
// bpv_checker
// Port-level checks of the valuation unit, bound to the top level.
// ----------------------------------------------------------------------------
module bpv_checker
   import bpv_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [VAL_W-1:0]   rsp_valuation,
   input logic               rsp_divides,
   input logic               rsp_bad_input
);

   // an accepted beat makes the unit busy and gives no response next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not raise busy");

   // a response only ends a busy stretch
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response strobe outside the end of a busy stretch");

   // divides flag follows the valuation
   a_divides: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_divides == (rsp_valuation != '0)))
      else $error("divides flag disagrees with valuation");

   // a bad request reports a zero valuation
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_input) |-> (rsp_valuation == '0))
      else $error("bad request with nonzero valuation");

endmodule

bind binomial_prime_valuation_unit bpv_checker u_bpv_checker (.*);
